### src/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

  // Command codes carried on in_tuser; code 3 is unused and returns a flag-free result, heap unchanged
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_PEEK    = 2'd2
  } cmd_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 8;

  // Controller -> datapath commands, one cycle each
  typedef struct packed {
    logic clear_res;  // zero result fields at start of a transaction
    logic set_empty;  // extract/peek on empty heap
    logic set_full;   // insert dropped
    logic ins_setup;  // hole at tail, latch value, bump count
    logic rd_parent;  // read parent of hole on port A
    logic move_up;    // parent moves down into hole, hole climbs
    logic write_v;    // park held value in the hole
    logic ext_read;   // read root (A) and tail (B)
    logic ext_take;   // latch root as result, tail as held value
    logic rd_kids;    // read left (A) and right (B) children
    logic move_down;  // chosen child moves up, hole descends
    logic peek_read;  // read root on port A
    logic peek_take;  // latch root as result
    logic out_load;   // push result into output register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_full;
    logic is_empty;
    logic hole_zero;
    logic up_less;    // held value strictly below parent
    logic lc_ok;      // hole has a left child in range
    logic dn_move;    // smaller child strictly below held value
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

### src/binary_min_heap_queue.sv
// Channel | Dir | Ports                 | Contents
// in_     | in  | tvalid tready tdata   | tdata[31:0] value; tuser[1:0] cmd
// out_    | out | tvalid tready tdata   | tdata[31:0] min_value, [39:32] occupancy;
//         |     | tuser                 | tuser[0] empty_res, [1] full_res
//
// One transaction at a time; each heap level takes a RAM read, then a compare/move.
// Insert climbs L levels toward the root (L <= 7 at 128); extract sifts down L levels (L <= 6).
// Synchronous active-low reset empties the heap; storage is not cleared.
// A stalled output holds the controller in its result state; the next command is
// accepted while the previous result still waits in the output register.
`default_nettype none

module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [DATA_W-1:0]          in_tdata,   // value
  input  wire logic [1:0]                 in_tuser,   // cmd
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [DATA_W+OCC_W-1:0]         out_tdata,  // min_value, occupancy
  output logic [1:0]                      out_tuser   // empty_res, full_res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### src/bmhq_dp.sv
`default_nettype none

module bmhq_dp
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [DATA_W-1:0]    in_value,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [DATA_W+OCC_W-1:0]   out_tdata,
  output logic [1:0]                out_tuser
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;

  // Heap storage
  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            hole_r, hole_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic                     empty_r, empty_nxt;
  logic                     full_r, full_nxt;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;

  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]        out_min_r;
  logic [OCC_W-1:0]         out_occ_r;
  logic                     out_empty_r, out_full_r;

  logic [AW-1:0]            parent;
  logic [LW-1:0]            lc_w, rc_w, cnt_w;
  logic                     rc_ok, sel_right;
  logic signed [DATA_W-1:0] child_val;
  logic [AW-1:0]            child_idx;
  logic [AW-1:0]            addr_a, addr_b;
  logic                     rd_en;
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;

  // Heap index arithmetic
  assign parent = AW'((hole_r - 1'b1) >> 1);
  assign lc_w   = {1'b0, hole_r, 1'b1};
  assign rc_w   = {1'b0, hole_r, 1'b0} + LW'(2);
  assign cnt_w  = LW'(count_r);
  assign rc_ok  = rc_w < cnt_w;

  // Child select: right only when strictly smaller, left wins ties
  assign sel_right = rc_ok && (rd_b_r < rd_a_r);
  assign child_val = sel_right ? rd_b_r : rd_a_r;
  assign child_idx = sel_right ? rc_w[AW-1:0] : lc_w[AW-1:0];

  // Status
  always_comb begin
    stat.is_full   = count_r == CW'(CAPACITY);
    stat.is_empty  = count_r == '0;
    stat.hole_zero = hole_r == '0;
    stat.up_less   = v_r < rd_a_r;
    stat.lc_ok     = lc_w < cnt_w;
    stat.dn_move   = child_val < v_r;
    stat.out_free  = !out_tvalid_r || out_tready;
  end

  // Read addresses
  always_comb begin
    addr_a = lc_w[AW-1:0];
    addr_b = rc_w[AW-1:0];
    if (cmd.rd_parent) begin
      addr_a = parent;
    end else if (cmd.ext_read || cmd.peek_read) begin
      addr_a = '0;
    end
    if (cmd.ext_read) begin
      addr_b = AW'(count_r - 1'b1);
    end
  end

  // Memory is read only on cycles that fetch operands
  assign rd_en = cmd.rd_parent || cmd.rd_kids || cmd.ext_read || cmd.peek_read;

  // Write port
  always_comb begin
    wr_en   = cmd.write_v || cmd.move_up || cmd.move_down;
    wr_data = child_val;
    if (cmd.write_v) begin
      wr_data = v_r;
    end else if (cmd.move_up) begin
      wr_data = rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[hole_r] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  // Working registers
  always_comb begin
    count_nxt = count_r;
    hole_nxt  = hole_r;
    v_nxt     = v_r;
    min_nxt   = min_r;
    empty_nxt = empty_r;
    full_nxt  = full_r;
    if (cmd.clear_res) begin
      min_nxt   = '0;
      empty_nxt = 1'b0;
      full_nxt  = 1'b0;
    end
    if (cmd.set_empty) begin
      empty_nxt = 1'b1;
    end
    if (cmd.set_full) begin
      full_nxt = 1'b1;
    end
    if (cmd.ins_setup) begin
      hole_nxt  = AW'(count_r);
      v_nxt     = in_value;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.move_up) begin
      hole_nxt = parent;
    end
    if (cmd.ext_take) begin
      min_nxt   = rd_a_r;
      v_nxt     = rd_b_r;
      count_nxt = count_r - 1'b1;
      hole_nxt  = '0;
    end
    if (cmd.move_down) begin
      hole_nxt = child_idx;
    end
    if (cmd.peek_take) begin
      min_nxt = rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    hole_r  <= hole_nxt;
    v_r     <= v_nxt;
    min_r   <= min_nxt;
    empty_r <= empty_nxt;
    full_r  <= full_nxt;
  end

  // Output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    if (cmd.out_load) begin
      out_min_r   <= min_r;
      out_occ_r   <= OCC_W'(count_r);
      out_empty_r <= empty_r;
      out_full_r  <= full_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_occ_r, out_min_r};
  assign out_tuser  = {out_full_r, out_empty_r};

endmodule

`default_nettype wire

### src/bmhq_ctrl.sv
`default_nettype none

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic [1:0] in_cmd,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EXT_TAKE,
    S_DN_CHK,
    S_DN_CMP,
    S_PEEK_TAKE,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = state_r == S_IDLE;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.clear_res = 1'b1;
          state_nxt     = S_RESULT;
          case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (stat.is_full) begin
                cmd.set_full = 1'b1;
              end else begin
                cmd.ins_setup = 1'b1;
                state_nxt     = S_UP_CHK;
              end
            end
            CMD_EXTRACT: begin
              if (stat.is_empty) begin
                cmd.set_empty = 1'b1;
              end else begin
                cmd.ext_read = 1'b1;
                state_nxt    = S_EXT_TAKE;
              end
            end
            CMD_PEEK: begin
              if (stat.is_empty) begin
                cmd.set_empty = 1'b1;
              end else begin
                cmd.peek_read = 1'b1;
                state_nxt     = S_PEEK_TAKE;
              end
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      // Sift up: one parent read, one compare per level
      S_UP_CHK: begin
        if (stat.hole_zero) begin
          cmd.write_v = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_less) begin
          cmd.move_up = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.write_v = 1'b1;
          state_nxt   = S_RESULT;
        end
      end
      S_EXT_TAKE: begin
        cmd.ext_take = 1'b1;
        state_nxt    = S_DN_CHK;
      end
      // Sift down: both children read together, then compare
      S_DN_CHK: begin
        if (stat.lc_ok) begin
          cmd.rd_kids = 1'b1;
          state_nxt   = S_DN_CMP;
        end else begin
          cmd.write_v = 1'b1;
          state_nxt   = S_RESULT;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_move) begin
          cmd.move_down = 1'b1;
          state_nxt     = S_DN_CHK;
        end else begin
          cmd.write_v = 1'b1;
          state_nxt   = S_RESULT;
        end
      end
      S_PEEK_TAKE: begin
        cmd.peek_take = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### test/tb_top.sv
module tb_top;
  import bmhq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_DEPTH     = 128;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  // code 3 has no command behind it; the block must answer it with a flag-free result
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  typedef struct packed {
    logic [31:0] min_value;
    logic        empty_res;
    logic        full_res;
    logic [7:0]  occupancy;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata;         // value
  logic [1:0] in_tuser;                // cmd
  logic out_tvalid;
  logic out_tready;
  logic [DATA_W+OCC_W-1:0] out_tdata;  // min_value, occupancy
  logic [1:0] out_tuser;               // empty_res, full_res

  // Mirror of the heap contents, updated on every accepted transaction
  logic signed [31:0] heap_mirror [HEAP_DEPTH];
  int unsigned        mirror_count;
  heap_result_t       pending_results[$];
  heap_result_t       oldest_expected;
  int unsigned        error_count;
  int unsigned        quiet_cycles;
  bit                 idle_en;

  binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [31:0] held;
    held = heap_mirror[a];
    heap_mirror[a] = heap_mirror[b];
    heap_mirror[b] = held;
  endfunction

  // Apply one command to the mirror and return the result it must produce
  function automatic heap_result_t apply_command(logic [1:0] cmd, logic [31:0] value);
    heap_result_t res;
    int unsigned pos, up, lc, rc, best;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        if (mirror_count >= HEAP_DEPTH) begin
          res.full_res = 1'b1;
        end else begin
          pos = mirror_count;
          heap_mirror[pos] = value;
          // climb while strictly below the parent
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_mirror[pos] >= heap_mirror[up]) break;
            swap_entries(pos, up);
            pos = up;
          end
          mirror_count++;
        end
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (mirror_count == 0) begin
          res.empty_res = 1'b1;
        end else begin
          res.min_value = heap_mirror[0];
          if (cmd == CMD_EXTRACT) begin
            mirror_count--;
            heap_mirror[0] = heap_mirror[mirror_count];
            pos = 0;
            // descend; a tie between children keeps the left one
            while (1) begin
              lc = 2 * pos + 1;
              rc = 2 * pos + 2;
              best = pos;
              if (lc < mirror_count && heap_mirror[lc] < heap_mirror[best]) best = lc;
              if (rc < mirror_count && heap_mirror[rc] < heap_mirror[best]) best = rc;
              if (best == pos) break;
              swap_entries(pos, best);
              pos = best;
            end
          end
        end
      end
      default: ;
    endcase
    res.occupancy = mirror_count[7:0];
    return res;
  endfunction

  // Values lean toward the extremes and a narrow band around zero for ties
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1:       return 32'h8000_0000 + $urandom_range(0, 3);
      2, 3:    return $urandom_range(0, 8) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Keep the fill level moving: more extracts once the heap is nearly full
  function automatic logic [1:0] pick_command();
    int unsigned r, ins_limit;
    r = $urandom_range(0, 99);
    ins_limit = (mirror_count > 100) ? 40 : 62;
    if (r < 4) return CMD_UNUSED;
    if (r < 20) return CMD_PEEK;
    if (r < ins_limit) return CMD_INSERT;
    return CMD_EXTRACT;
  endfunction

  // Send one transaction, with an optional idle burst in front of it
  task automatic send_item(logic [1:0] cmd, logic [31:0] value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_command(cmd, value));
  endtask

  task automatic check_field(string field_name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field_name, want, got);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%h",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        oldest_expected = pending_results.pop_front();
        check_field("min_value", oldest_expected.min_value, out_tdata[31:0]);
        check_field("occupancy", oldest_expected.occupancy, out_tdata[39:32]);
        check_field("empty_res", oldest_expected.empty_res, out_tuser[0]);
        check_field("full_res",  oldest_expected.full_res,  out_tuser[1]);
      end
    end
  end

  // Result-side backpressure in random bursts
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Extract, peek and the unused code on an empty heap
  task automatic test_empty_heap();
    send_item(CMD_PEEK, $urandom);
    send_item(CMD_EXTRACT, $urandom);
    send_item(CMD_UNUSED, $urandom);
  endtask

  // Field extremes, duplicates, then drain back to empty
  task automatic test_extreme_values();
    send_item(CMD_INSERT, 32'h7FFF_FFFF);
    send_item(CMD_INSERT, 32'h8000_0000);
    send_item(CMD_INSERT, 32'h0000_0000);
    send_item(CMD_INSERT, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h0000_0001);
    send_item(CMD_INSERT, 32'h8000_0000);
    send_item(CMD_INSERT, 32'h0000_0000);
    send_item(CMD_INSERT, 32'h7FFF_FFFE);
    send_item(CMD_PEEK, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    repeat (8) send_item(CMD_EXTRACT, $urandom);
  endtask

  // Fill to capacity, push past it, then drain including one empty extract
  task automatic test_full_heap();
    while (mirror_count < HEAP_DEPTH) send_item(CMD_INSERT, pick_value());
    repeat (3) send_item(CMD_INSERT, pick_value());
    send_item(CMD_PEEK, $urandom);
    while (mirror_count > 0) send_item(CMD_EXTRACT, $urandom);
    send_item(CMD_EXTRACT, $urandom);
  endtask

  task automatic test_random_mix(int unsigned n_items);
    repeat (n_items) send_item(pick_command(), pick_value());
  endtask

  // Same mix with both sides always ready
  task automatic test_back_to_back(int unsigned n_items);
    idle_en = 1'b0;
    repeat (n_items) send_item(pick_command(), pick_value());
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    mirror_count = 0;
    error_count  = 0;
    quiet_cycles = 0;
    idle_en      = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_heap();
    test_extreme_values();
    test_full_heap();
    test_random_mix(280);
    test_back_to_back(140);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
